// ----- hdl/brs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// brs_pkg
// Shared types, codes and reset constants of the bracketing root search block.
// ----------------------------------------------------------------------------
package brs_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int REL_W           = 16;
  localparam int ITER_W          = 16;
  localparam int CFG_IDX_W       = 2;

  localparam logic [REL_W-1:0]  REL_TOL_RST  = 16'd66;
  localparam int                COST_TOL_RST = 66;
  localparam logic [ITER_W-1:0] MAX_ITER_RST = 16'd100;

  localparam logic [CFG_IDX_W-1:0] REG_REL_TOL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COST_TOL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 2'd2;

  localparam logic MODE_START = 1'b0;

  typedef enum logic [0:0] {
    OP_MUL,
    OP_DIV
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_stat_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LOWER,
    PH_UPPER,
    PH_COST
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BEGIN,
    S_COST,
    S_ORDER,
    S_STEP,
    S_ISSUE,
    S_WAIT,
    S_SAT,
    S_CHECK,
    S_TOLCHK,
    S_BISECT,
    S_EMIT
  } state_t;

  // micro-op program of the shared unit; U_TOL is issued ahead of the rest
  typedef enum logic [3:0] {
    U_SEC_MUL,
    U_SEC_DIV,
    U_T1_M1,
    U_T1_M2,
    U_T1_DEN,
    U_T1_DIV,
    U_T2_M1,
    U_T2_M2,
    U_T2_DEN,
    U_T2_DIV,
    U_T3_M1,
    U_T3_M2,
    U_T3_DEN,
    U_T3_DIV,
    U_TB,
    U_TOL
  } micro_t;

endpackage
`default_nettype wire

// ----- hdl/brent_root_search_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// brent_root_search_step
// Bracketing root search (Brent's method) with the function evaluated outside.
// ----------------------------------------------------------------------------
// A start item (mode 0) loads the bracket and, if given, f at either end; the
// block answers with the next point whose f it needs. Each later item (mode 1)
// brings f at that point, and the answer is the next point or, with done_res
// set, the root. Values are signed fixed point, VALUE_WIDTH bits. One item is
// worked at a time and req_stall is high while it is in progress. The time a
// search step takes is set by the single shared multiply/divide unit, which
// retires one bit per cycle: each inverse quadratic term costs two value-wide
// multiplies, one denominator multiply and a triple-width division. A finished
// result sits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module brent_root_search_step
  import brs_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration
  input  wire logic                        cfg_write,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [((VALUE_WIDTH-1 > REL_W) ? VALUE_WIDTH-1 : REL_W)-1:0] cfg_data,
  // item channel
  input  wire logic                        req_valid,
  output logic                             req_stall,
  input  wire logic                        mode,
  input  wire logic signed [VALUE_WIDTH-1:0] lower_bound,
  input  wire logic signed [VALUE_WIDTH-1:0] upper_bound,
  input  wire logic                        lower_value_given,
  input  wire logic                        upper_value_given,
  input  wire logic signed [VALUE_WIDTH-1:0] lower_value,
  input  wire logic signed [VALUE_WIDTH-1:0] upper_value,
  input  wire logic signed [VALUE_WIDTH-1:0] function_value,
  // result channel
  output logic                             res_valid,
  input  wire logic                        res_stall,
  output logic signed [VALUE_WIDTH-1:0]    point,
  output logic                             done_res,
  output logic [ITER_W-1:0]                iterations
);

  localparam int VW    = VALUE_WIDTH;
  localparam int WW    = 3 * VW + 4;       // widest interpolation intermediate
  localparam int CNT_W = $clog2(WW);

  // configuration registers
  logic [REL_W-1:0]  rel_tol;
  logic [VW-2:0]     cost_tol;
  logic [ITER_W-1:0] max_iter;

  // search state
  logic signed [VW-1:0] pa, pb, pc, pd;
  logic signed [VW-1:0] fa, fb, fc;
  logic signed [VW-1:0] last_query;
  logic                 bisect_flag;
  logic                 upper_pending;
  logic [ITER_W-1:0]    step_count;
  phase_t               phase;
  logic                 emit_done;
  logic                 stop_r;

  state_t state, state_next;
  micro_t op_idx;

  // scratch
  logic signed [VW-1:0] fin;
  logic signed [VW-1:0] pnew;
  logic [WW-1:0]        tmp;
  logic [WW-1:0]        den;
  logic [WW-1:0]        acc;
  logic [WW-1:0]        tb;

  // shared unit
  arith_req_t       u_req;
  arith_stat_t      u_stat;
  logic [CNT_W-1:0] u_cnt;
  logic [WW-1:0]    u_a, u_b, u_res;

  logic accept;
  logic out_free;
  assign accept   = req_valid && !req_stall;
  assign out_free = !res_valid || !res_stall;

  // --------------------------------------------------------------------------
  // combinational helpers
  // --------------------------------------------------------------------------
  logic signed [VW:0]   fab, fba, fac, fbc;
  logic                 secant;
  logic [VW-1:0]        abs_b;
  logic signed [VW:0]   sum_ab, dif_ba;
  logic [VW:0]          abs_sum, abs_ba;
  logic signed [VW-1:0] mid;
  logic                 swap;
  logic [VW-1:0]        abs_fa, abs_fb, abs_fin;

  assign fab    = {fa[VW-1], fa} - {fb[VW-1], fb};
  assign fba    = {fb[VW-1], fb} - {fa[VW-1], fa};
  assign fac    = {fa[VW-1], fa} - {fc[VW-1], fc};
  assign fbc    = {fb[VW-1], fb} - {fc[VW-1], fc};
  assign secant = (fac == '0) || (fbc == '0);

  assign abs_b   = pb[VW-1] ? (~pb + 1'b1) : pb;
  assign sum_ab  = {pa[VW-1], pa} + {pb[VW-1], pb};
  assign dif_ba  = {pb[VW-1], pb} - {pa[VW-1], pa};
  assign abs_sum = sum_ab[VW] ? (~sum_ab + 1'b1) : sum_ab;
  assign abs_ba  = dif_ba[VW] ? (~dif_ba + 1'b1) : dif_ba;
  assign mid     = sum_ab[VW:1];

  assign abs_fa  = fa[VW-1] ? (~fa + 1'b1) : fa;
  assign abs_fb  = fb[VW-1] ? (~fb + 1'b1) : fb;
  assign abs_fin = fin[VW-1] ? (~fin + 1'b1) : fin;
  assign swap    = abs_fa < abs_fb;

  // opposite signs of f(a) and the new value, zero counts as neither
  logic opp;
  assign opp = (fa[VW-1] && !fin[VW-1] && (fin != '0)) ||
               (!fa[VW-1] && (fa != '0) && fin[VW-1]);

  // saturation of the interpolated point
  logic                 acc_fits;
  logic signed [VW-1:0] acc_sat;
  assign acc_fits = (&acc[WW-1:VW-1]) || !(|acc[WW-1:VW-1]);
  always_comb begin
    if (acc_fits) begin
      acc_sat = acc[VW-1:0];
    end else if (acc[WW-1]) begin
      acc_sat = {1'b1, {(VW-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(VW-1){1'b1}}};
    end
  end

  // acceptance tests on the candidate point
  logic signed [VW+2:0] q3, b4, p4, lo4, hi4;
  logic signed [VW:0]   dif_pb, dif_bc, dif_cd;
  logic [VW:0]          abs_pb, abs_bc, abs_cd, d_ref;
  logic [VW+1:0]        two_pb;
  logic                 bis_span, bis_step, bis_tol, bis;
  logic                 tol_hit;

  assign q3  = {{2{pa[VW-1]}}, pa, 1'b0} + {{3{pa[VW-1]}}, pa} + {{3{pb[VW-1]}}, pb};
  assign b4  = {pb[VW-1], pb, 2'b00};
  assign p4  = {pnew[VW-1], pnew, 2'b00};
  assign lo4 = (q3 < b4) ? q3 : b4;
  assign hi4 = (q3 < b4) ? b4 : q3;

  assign dif_pb = {pnew[VW-1], pnew} - {pb[VW-1], pb};
  assign dif_bc = {pb[VW-1], pb} - {pc[VW-1], pc};
  assign dif_cd = {pc[VW-1], pc} - {pd[VW-1], pd};
  assign abs_pb = dif_pb[VW] ? (~dif_pb + 1'b1) : dif_pb;
  assign abs_bc = dif_bc[VW] ? (~dif_bc + 1'b1) : dif_bc;
  assign abs_cd = dif_cd[VW] ? (~dif_cd + 1'b1) : dif_cd;
  assign two_pb = {abs_pb, 1'b0};
  assign d_ref  = bisect_flag ? abs_bc : abs_cd;

  assign bis_span = (p4 < lo4) || (p4 > hi4);
  assign bis_step = two_pb >= {1'b0, d_ref};
  assign bis_tol  = {{(WW-VW-1-REL_W){1'b0}}, d_ref, {REL_W{1'b0}}} < tb;
  assign bis      = bis_span || bis_step || bis_tol;

  // bracket width against the relative tolerance times |a+b|/2
  assign tol_hit = {{(WW-VW-2-REL_W){1'b0}}, abs_ba, {(REL_W+1){1'b0}}} < tb;

  // --------------------------------------------------------------------------
  // operand selection for the shared unit
  // --------------------------------------------------------------------------
  always_comb begin
    u_a   = '0;
    u_b   = '0;
    u_cnt = CNT_W'(VW);
    u_req.op = OP_MUL;
    case (op_idx)
      U_SEC_MUL: begin
        u_a   = {{(WW-VW){fb[VW-1]}}, fb};
        u_b   = {{(WW-VW-1){dif_ba[VW]}}, dif_ba};
        u_cnt = CNT_W'(VW + 1);
      end
      U_SEC_DIV: begin
        u_a      = tmp;
        u_b      = {{(WW-VW-1){fab[VW]}}, fab};
        u_cnt    = CNT_W'(2 * VW);
        u_req.op = OP_DIV;
      end
      U_T1_M1: begin
        u_a = {{(WW-VW){pa[VW-1]}}, pa};
        u_b = {{(WW-VW){fb[VW-1]}}, fb};
      end
      U_T1_M2, U_T2_M2: begin
        u_a = tmp;
        u_b = {{(WW-VW){fc[VW-1]}}, fc};
      end
      U_T1_DEN: begin
        u_a   = {{(WW-VW-1){fab[VW]}}, fab};
        u_b   = {{(WW-VW-1){fac[VW]}}, fac};
        u_cnt = CNT_W'(VW + 1);
      end
      U_T1_DIV, U_T2_DIV, U_T3_DIV: begin
        u_a      = tmp;
        u_b      = den;
        u_cnt    = CNT_W'(3 * VW);
        u_req.op = OP_DIV;
      end
      U_T2_M1: begin
        u_a = {{(WW-VW){pb[VW-1]}}, pb};
        u_b = {{(WW-VW){fa[VW-1]}}, fa};
      end
      U_T2_DEN: begin
        u_a   = {{(WW-VW-1){fba[VW]}}, fba};
        u_b   = {{(WW-VW-1){fbc[VW]}}, fbc};
        u_cnt = CNT_W'(VW + 1);
      end
      U_T3_M1: begin
        u_a = {{(WW-VW){pc[VW-1]}}, pc};
        u_b = {{(WW-VW){fa[VW-1]}}, fa};
      end
      U_T3_M2: begin
        u_a = tmp;
        u_b = {{(WW-VW){fb[VW-1]}}, fb};
      end
      U_T3_DEN: begin
        u_a   = {{(WW-VW-1){fac[VW]}}, fac};
        u_b   = {{(WW-VW-1){fbc[VW]}}, fbc};
        u_cnt = CNT_W'(VW + 1);
      end
      U_TB: begin
        u_a   = {{(WW-VW){1'b0}}, abs_b};
        u_b   = {{(WW-REL_W){1'b0}}, rel_tol};
        u_cnt = CNT_W'(REL_W);
      end
      U_TOL: begin
        u_a   = {{(WW-VW-1){1'b0}}, abs_sum};
        u_b   = {{(WW-REL_W){1'b0}}, rel_tol};
        u_cnt = CNT_W'(REL_W);
      end
      default: begin
        u_a = '0;
      end
    endcase
  end

  brs_arith #(
    .WW    (WW),
    .CNT_W (CNT_W)
  ) u_arith (
    .clk    (clk),
    .rst    (rst),
    .req    (u_req),
    .count  (u_cnt),
    .opa    (u_a),
    .opb    (u_b),
    .stat   (u_stat),
    .result (u_res)
  );

  // --------------------------------------------------------------------------
  // sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (mode == MODE_START) begin
            state_next = (lower_value_given && upper_value_given) ? S_BEGIN : S_EMIT;
          end else begin
            case (phase)
              PH_LOWER: state_next = upper_pending ? S_EMIT : S_BEGIN;
              PH_UPPER: state_next = S_BEGIN;
              PH_COST:  state_next = S_COST;
              default:  state_next = S_EMIT;
            endcase
          end
        end
      end
      S_BEGIN:  state_next = S_STEP;
      S_COST:   state_next = S_ORDER;
      S_ORDER:  state_next = S_ISSUE;
      S_STEP:   state_next = (fab == '0) ? S_BISECT : S_ISSUE;
      S_ISSUE:  state_next = S_WAIT;
      S_WAIT: begin
        if (u_stat.done) begin
          case (op_idx)
            U_SEC_DIV, U_T3_DIV: state_next = S_SAT;
            U_TB:                state_next = S_CHECK;
            U_TOL:               state_next = S_TOLCHK;
            default:             state_next = S_ISSUE;
          endcase
        end
      end
      S_SAT:    state_next = S_ISSUE;
      S_CHECK:  state_next = S_EMIT;
      S_TOLCHK: state_next = (stop_r || tol_hit) ? S_EMIT : S_STEP;
      S_BISECT: state_next = S_EMIT;
      S_EMIT:   state_next = out_free ? S_IDLE : S_EMIT;
      default:  state_next = S_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    req_stall   = (state != S_IDLE);
    u_req.start = (state == S_ISSUE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // micro-op pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      op_idx <= U_SEC_MUL;
    end else begin
      case (state)
        S_ORDER: op_idx <= U_TOL;
        S_STEP:  op_idx <= secant ? U_SEC_MUL : U_T1_M1;
        S_SAT:   op_idx <= U_TB;
        S_WAIT: begin
          if (u_stat.done) begin
            op_idx <= micro_t'(op_idx + 4'd1);
          end
        end
        default: op_idx <= op_idx;
      endcase
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rel_tol  <= REL_TOL_RST;
      cost_tol <= (VW-1)'(COST_TOL_RST);
      max_iter <= MAX_ITER_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_REL_TOL:  rel_tol  <= cfg_data[REL_W-1:0];
        REG_COST_TOL: cost_tol <= cfg_data[VW-2:0];
        REG_MAX_ITER: max_iter <= cfg_data[ITER_W-1:0];
        default:      rel_tol  <= rel_tol;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // search state updates
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pa            <= '0;
      pb            <= '0;
      pc            <= '0;
      pd            <= '0;
      fa            <= '0;
      fb            <= '0;
      fc            <= '0;
      last_query    <= '0;
      bisect_flag   <= 1'b1;
      upper_pending <= 1'b0;
      step_count    <= '0;
      phase         <= PH_IDLE;
      emit_done     <= 1'b0;
      stop_r        <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (mode == MODE_START) begin
              // start item: a new search replaces any search in progress
              pa            <= lower_bound;
              pb            <= upper_bound;
              fa            <= lower_value;
              fb            <= upper_value;
              upper_pending <= !upper_value_given;
              step_count    <= '0;
              emit_done     <= 1'b0;
              if (!lower_value_given) begin
                phase      <= PH_LOWER;
                last_query <= lower_bound;
              end else if (!upper_value_given) begin
                phase      <= PH_UPPER;
                last_query <= upper_bound;
              end
            end else begin
              case (phase)
                PH_LOWER: begin
                  fa        <= function_value;
                  emit_done <= 1'b0;
                  if (upper_pending) begin
                    phase      <= PH_UPPER;
                    last_query <= pb;
                  end
                end
                PH_UPPER: fb <= function_value;
                PH_COST:  emit_done <= 1'b0;
                // value while no search runs: repeat the last answer as done
                default:  emit_done <= 1'b1;
              endcase
            end
          end
        end
        S_BEGIN: begin
          // order a/b by |f|, c starts at a, first step treats as bisected
          if (swap) begin
            pa <= pb;
            pb <= pa;
            fa <= fb;
            fb <= fa;
          end
          pc          <= swap ? pb : pa;
          fc          <= swap ? fb : fa;
          pd          <= '0;
          bisect_flag <= 1'b1;
        end
        S_COST: begin
          stop_r <= {1'b0, abs_fin} < {2'b00, cost_tol};
          pd     <= pc;
          pc     <= pb;
          fc     <= fb;
          if (opp) begin
            pb <= last_query;
            fb <= fin;
          end else begin
            pa <= last_query;
            fa <= fin;
          end
        end
        S_ORDER: begin
          if (swap) begin
            pa <= pb;
            pb <= pa;
            fa <= fb;
            fb <= fa;
          end
          stop_r <= stop_r || (step_count >= max_iter);
        end
        S_STEP: step_count <= step_count + 1'b1;
        S_TOLCHK: begin
          if (stop_r || tol_hit) begin
            phase     <= PH_IDLE;
            emit_done <= 1'b1;
          end
        end
        S_CHECK: begin
          last_query  <= bis ? mid : pnew;
          bisect_flag <= bis;
          phase       <= PH_COST;
          emit_done   <= 1'b0;
        end
        S_BISECT: begin
          // zero denominator
          last_query  <= mid;
          bisect_flag <= 1'b1;
          phase       <= PH_COST;
          emit_done   <= 1'b0;
        end
        default: stop_r <= stop_r;
      endcase
    end
  end

  // interpolation scratch
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      fin <= function_value;
    end
    if (state == S_SAT) begin
      pnew <= acc_sat;
    end
    if (state == S_WAIT && u_stat.done) begin
      case (op_idx)
        U_SEC_MUL, U_T1_M1, U_T1_M2, U_T2_M1, U_T2_M2, U_T3_M1, U_T3_M2: tmp <= u_res;
        U_T1_DEN, U_T2_DEN, U_T3_DEN: den <= u_res;
        U_SEC_DIV: acc <= {{(WW-VW){pb[VW-1]}}, pb} + u_res;
        U_T1_DIV:  acc <= u_res;
        U_T2_DIV, U_T3_DIV: acc <= acc + u_res;
        U_TB, U_TOL: tb <= u_res;
        default: tmp <= tmp;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      point      <= last_query;
      done_res   <= emit_done;
      iterations <= step_count;
    end
  end

`ifndef SYNTHESIS
  a_start_idle_unit: assert property (@(posedge clk) disable iff (rst)
    u_req.start |-> !u_stat.busy)
    else $error("shared unit started while busy");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("item taken without work started");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == S_EMIT)
    else $error("result shown outside emit");

  a_done_ends_search: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && emit_done) |-> phase == PH_IDLE)
    else $error("done result while a search is still open");
`endif

endmodule
`default_nettype wire

// ----- hdl/brs_arith.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// brs_arith
// Shared iterative unit: signed shift-add multiply and restoring divide,
// one bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module brs_arith
  import brs_pkg::*;
#(
  parameter int WW    = 100,
  parameter int CNT_W = 7
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire arith_req_t        req,
  input  wire logic [CNT_W-1:0]  count,
  input  wire logic [WW-1:0]     opa,
  input  wire logic [WW-1:0]     opb,
  output arith_stat_t            stat,
  output logic [WW-1:0]          result
);

  logic             run;
  logic             fix;
  logic             done_r;
  arith_op_t        op_r;
  logic             neg;
  logic [WW-1:0]    mag_a;
  logic [WW-1:0]    mag_b;
  logic [WW-1:0]    rem;
  logic [WW-1:0]    quo;
  logic [CNT_W-1:0] cnt;

  logic [WW-1:0]    abs_a;
  logic [WW-1:0]    abs_b;
  logic [CNT_W-1:0] bit_idx;
  logic [WW-1:0]    trial;
  logic             fits;
  logic [WW-1:0]    mag_res;

  assign abs_a   = opa[WW-1] ? (~opa + 1'b1) : opa;
  assign abs_b   = opb[WW-1] ? (~opb + 1'b1) : opb;
  assign bit_idx = cnt - 1'b1;
  assign trial   = {rem[WW-2:0], mag_a[bit_idx]};
  assign fits    = trial >= mag_b;
  assign mag_res = (op_r == OP_MUL) ? rem : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      run    <= 1'b0;
      fix    <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
      end else if (run) begin
        if (cnt == CNT_W'(1)) begin
          run <= 1'b0;
          fix <= 1'b1;
        end
      end else if (fix) begin
        fix    <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      neg   <= opa[WW-1] ^ opb[WW-1];
      mag_a <= abs_a;
      mag_b <= abs_b;
      rem   <= '0;
      quo   <= '0;
      cnt   <= count;
    end else if (run) begin
      cnt <= cnt - 1'b1;
      if (op_r == OP_MUL) begin
        if (mag_b[0]) begin
          rem <= rem + mag_a;
        end
        mag_a <= {mag_a[WW-2:0], 1'b0};
        mag_b <= {1'b0, mag_b[WW-1:1]};
      end else begin
        rem <= fits ? (trial - mag_b) : trial;
        quo <= {quo[WW-2:0], fits};
      end
    end else if (fix) begin
      result <= neg ? (~mag_res + 1'b1) : mag_res;
    end
  end

  assign stat.busy = run | fix;
  assign stat.done = done_r;

endmodule
`default_nettype wire
